// ===== design/heat_index_calc_top_assert.svh =====
// Assertion macros for the heat index block.
`ifndef HEAT_INDEX_CALC_TOP_ASSERT_SVH
`define HEAT_INDEX_CALC_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define HIC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HIC_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HIC_ASSERT_NOW(lbl, ante, cons)
`define HIC_ASSERT_RESET(lbl, ante, cons)
`endif

`endif

// ===== design/hic_pkg.sv =====
`default_nettype none

package hic_pkg;

  typedef struct packed {
    logic signed [12:0] temperature_f;
    logic        [10:0] humidity_pct;
  } hic_in_t;

  typedef struct packed {
    logic signed [15:0] heat_index_f;
    logic               saturated;
    logic               used_regression;
  } hic_out_t;

endpackage

`default_nettype wire

// ===== design/heat_index_calc_top.sv =====
// Heat index calculator.
// The input channel takes one beat of temperature (1/16 degF, signed) and
// relative humidity (1/16 percent) at each rising edge where start is high
// and busy is low. busy is always low, so a new beat may be offered in every
// cycle and the block sustains one beat per clock.
// Each beat produces exactly one result beat on out_data, marked by out_valid
// for one cycle. The result carries the heat index in 1/16 degF, a flag that
// tells whether it was clipped to the 16-bit range, and a flag that tells
// whether the regression path was taken.
// The square root of the low-humidity correction sets the latency: it is a
// pipeline that resolves one root bit per stage, and the polynomial waits for
// it in a delay line.
// Results leave in the order the beats came in.
// The receiver cannot hold results off; out_valid is a strobe.
// Synchronous reset clears every valid bit, so no result beat appears for
// beats that were in flight when reset was asserted.
`default_nettype none

`include "heat_index_calc_top_assert.svh"

module heat_index_calc_top #(
  parameter int FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hic_pkg::hic_in_t  in_data,
  output logic              out_valid,
  output hic_pkg::hic_out_t out_data
);
  import hic_pkg::*;

  localparam int RT_W  = FRAC_BITS + 1;
  localparam int ARG_W = 2 * RT_W;
  localparam int RM_W  = RT_W + 2;
  localparam int DL_N  = RT_W - 2;
  localparam int LAT   = RT_W + 4;
  localparam int SH    = FRAC_BITS + 12;

  localparam longint C0 = -(((longint'(42379) << FRAC_BITS) + 500) / 1000);
  localparam longint C1 = ((longint'(204901523) << FRAC_BITS) + 50000000) / 100000000;
  localparam longint C2 = ((longint'(1014333127) << FRAC_BITS) + 50000000) / 100000000;
  localparam longint C3 = -(((longint'(22475541) << FRAC_BITS) + 50000000) / 100000000);
  localparam longint C4 = -(((longint'(683783) << FRAC_BITS) + 50000000) / 100000000);
  localparam longint C5 = -(((longint'(5481717) << FRAC_BITS) + 50000000) / 100000000);
  localparam longint C6 = ((longint'(122874) << FRAC_BITS) + 50000000) / 100000000;
  localparam longint C7 = ((longint'(85282) << FRAC_BITS) + 50000000) / 100000000;
  localparam longint C8 = -(((longint'(199) << FRAC_BITS) + 50000000) / 100000000);
  localparam longint C9 = ((longint'(5882) << FRAC_BITS) + 50000) / 100000;
  localparam longint C10 = ((longint'(2) << FRAC_BITS) + 50) / 100;
  localparam longint C0S = C0 * 65536;
  localparam longint RND = longint'(1) << (FRAC_BITS + 11);

  localparam int C1_W  = FRAC_BITS + 3;
  localparam int C2_W  = FRAC_BITS + 5;
  localparam int C3_W  = FRAC_BITS + 1;
  localparam int C4_W  = FRAC_BITS - 5;
  localparam int C5_W  = FRAC_BITS - 2;
  localparam int C6_W  = FRAC_BITS - 7;
  localparam int C7_W  = FRAC_BITS - 8;
  localparam int C8_W  = (FRAC_BITS >= 20) ? FRAC_BITS - 16 : 4;
  localparam int C9_W  = FRAC_BITS - 4;
  localparam int C10_W = FRAC_BITS - 4;

  localparam logic signed [C1_W-1:0]  K1  = C1[C1_W-1:0];
  localparam logic signed [C2_W-1:0]  K2  = C2[C2_W-1:0];
  localparam logic signed [C3_W-1:0]  K3  = C3[C3_W-1:0];
  localparam logic signed [C4_W-1:0]  K4  = C4[C4_W-1:0];
  localparam logic signed [C5_W-1:0]  K5  = C5[C5_W-1:0];
  localparam logic signed [C6_W-1:0]  K6  = C6[C6_W-1:0];
  localparam logic signed [C7_W-1:0]  K7  = C7[C7_W-1:0];
  localparam logic signed [C8_W-1:0]  K8  = C8[C8_W-1:0];
  localparam logic        [C9_W-1:0]  K9  = C9[C9_W-1:0];
  localparam logic signed [C10_W-1:0] K10 = C10[C10_W-1:0];

  typedef struct packed {
    logic signed [63:0] s;
    logic signed [15:0] simple;
    logic               rgr;
    logic               low;
    logic        [7:0]  hl;
  } pl_t;

  // Stage 1: squares, linear terms, estimate, correction operands.
  logic signed [12:0] t_in;
  logic signed [11:0] h_in;
  logic signed [13:0] dt;
  logic signed [14:0] dd;
  logic        [FRAC_BITS+4:0] dk;
  logic signed [12:0] hs;
  logic signed [13:0] ts;
  logic ge80, low_nxt, high_nxt;

  logic signed [12:0] t1_r;
  logic signed [11:0] h1_r;
  logic signed [25:0] t2_r;
  logic signed [22:0] h2_r;
  logic signed [24:0] th_r;
  logic signed [23:0] x1_r;
  logic signed [C1_W+12:0] p1_r;
  logic signed [C2_W+11:0] p2_r;
  logic signed [26:0] hh_r;
  logic [ARG_W-1:0] arg_r;
  logic rgr1_r, low1_r, high1_r;
  logic [7:0] hl1_r;

  assign t_in = in_data.temperature_f;
  assign h_in = $signed({1'b0, in_data.humidity_pct});
  assign dt = 14'(t_in) - 14'sd1520;
  assign dd = 15'sd272 - ((dt < 0) ? -15'(dt) : 15'(dt));
  assign dk = dd[8:0] * K9;
  assign hs = 13'(h_in) - 13'sd1360;
  assign ts = 14'sd1392 - 14'(t_in);
  assign ge80 = t_in >= 13'sd1280;
  assign low_nxt = ge80 && (h_in < 12'sd208) && (t_in <= 13'sd1792);
  assign high_nxt = ge80 && !low_nxt && (h_in > 12'sd1360) && (t_in <= 13'sd1392);

  always_ff @(posedge clk) begin
    t1_r    <= t_in;
    h1_r    <= h_in;
    t2_r    <= t_in * t_in;
    h2_r    <= h_in * h_in;
    th_r    <= t_in * h_in;
    x1_r    <= 24'sd1100 * 24'(t_in) - 24'sd164800 + 24'sd47 * 24'(h_in);
    p1_r    <= K1 * t_in;
    p2_r    <= K2 * h_in;
    hh_r    <= hs * ts;
    arg_r   <= low_nxt ? (ARG_W'(dk) << (FRAC_BITS - 4)) : '0;
    rgr1_r  <= (24'sd1100 * 24'(t_in) - 24'sd164800 + 24'sd47 * 24'(h_in)) >= 24'sd1264000;
    low1_r  <= low_nxt;
    high1_r <= high_nxt;
    hl1_r   <= 8'(12'sd208 - h_in);
  end

  // Stage 2: third- and fourth-order products and reciprocal for the estimate.
  logic signed [37:0] t2h_r;
  logic signed [35:0] th2_r;
  logic signed [48:0] t2h2_r;
  logic signed [C3_W+24:0] p3_r;
  logic signed [C4_W+25:0] p4_r;
  logic signed [C5_W+22:0] p5_r;
  logic signed [C10_W+26:0] hc_r;
  logic [47:0] qp_r;
  logic signed [C1_W+12:0] p1b_r;
  logic signed [C2_W+11:0] p2b_r;
  logic rgr2_r, low2_r;
  logic [7:0] hl2_r;
  logic [23:0] y_nxt;

  assign y_nxt = 24'(x1_r + 24'sd5000500);

  always_ff @(posedge clk) begin
    t2h_r  <= t2_r * h1_r;
    th2_r  <= t1_r * h2_r;
    t2h2_r <= t2_r * h2_r;
    p3_r   <= K3 * th_r;
    p4_r   <= K4 * t2_r;
    p5_r   <= K5 * h2_r;
    hc_r   <= high1_r ? K10 * hh_r : '0;
    qp_r   <= y_nxt * 24'd8589935;
    p1b_r  <= p1_r;
    p2b_r  <= p2_r;
    rgr2_r <= rgr1_r;
    low2_r <= low1_r;
    hl2_r  <= hl1_r;
  end

  // Stage 3: coefficient products of the third- and fourth-order terms and first partial sums.
  logic signed [C6_W+37:0] p6_r;
  logic signed [C7_W+35:0] p7_r;
  logic signed [C8_W+48:0] p8_r;
  logic signed [63:0] sa1_r, sa2_r;
  logic signed [15:0] simple3_r;
  logic rgr3_r, low3_r;
  logic [7:0] hl3_r;

  always_ff @(posedge clk) begin
    p6_r      <= K6 * t2h_r;
    p7_r      <= K7 * th2_r;
    p8_r      <= K8 * t2h2_r;
    sa1_r     <= C0S + (64'(p1b_r) <<< 12) + (64'(p2b_r) <<< 12) + (64'(hc_r) <<< 8);
    sa2_r     <= (64'(p3_r) <<< 8) + (64'(p4_r) <<< 8) + (64'(p5_r) <<< 8);
    simple3_r <= $signed({1'b0, qp_r[47:33]}) - 16'sd5000;
    rgr3_r    <= rgr2_r;
    low3_r    <= low2_r;
    hl3_r     <= hl2_r;
  end

  // Stage 4 and delay line up to the end of the root pipeline.
  pl_t dl_r [0:DL_N-1];

  always_ff @(posedge clk) begin
    dl_r[0].s      <= sa1_r + sa2_r + (64'(p6_r) <<< 4) + (64'(p7_r) <<< 4) + 64'(p8_r);
    dl_r[0].simple <= simple3_r;
    dl_r[0].rgr    <= rgr3_r;
    dl_r[0].low    <= low3_r;
    dl_r[0].hl     <= hl3_r;
    for (int k = 1; k < DL_N; k++) begin
      dl_r[k] <= dl_r[k-1];
    end
  end

  // Square root, one result bit per stage.
  logic [RM_W-1:0]  sq_rem_r  [0:RT_W-2];
  logic [RT_W-1:0]  sq_root_r [0:RT_W-1];
  logic [ARG_W-1:0] sq_arg_r  [0:RT_W-2];

  for (genvar j = 0; j < RT_W; j++) begin : g_sqrt
    localparam int I = RT_W - 1 - j;
    logic [RM_W-1:0]  rin, rsh, trial;
    logic [RT_W-1:0]  qin;
    logic [ARG_W-1:0] ain;
    logic             take;

    if (j == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign ain = arg_r;
    end else begin : g_next
      assign rin = sq_rem_r[j-1];
      assign qin = sq_root_r[j-1];
      assign ain = sq_arg_r[j-1];
    end

    assign rsh   = {rin[RM_W-3:0], ain[2*I+1 -: 2]};
    assign trial = {qin, 2'b01};
    assign take  = rsh >= trial;

    always_ff @(posedge clk) begin
      sq_root_r[j] <= {qin[RT_W-2:0], take};
    end

    if (j < RT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        sq_rem_r[j] <= take ? rsh - trial : rsh;
        sq_arg_r[j] <= ain;
      end
    end
  end

  // Low-humidity correction, rounding, saturation.
  logic [RT_W+7:0] m_r;
  pl_t pe_r, pf_r;
  logic signed [63:0] rnd, hv;
  hic_out_t out_nxt, out_data_r;

  always_ff @(posedge clk) begin
    m_r         <= dl_r[DL_N-1].hl * sq_root_r[RT_W-1];
    pe_r        <= dl_r[DL_N-1];
    pf_r.s      <= pe_r.low ? (pe_r.s - (64'(m_r) << 10)) : pe_r.s;
    pf_r.simple <= pe_r.simple;
    pf_r.rgr    <= pe_r.rgr;
    pf_r.low    <= pe_r.low;
    pf_r.hl     <= pe_r.hl;
  end

  assign rnd = pf_r.s + RND;
  assign hv  = rnd >>> SH;

  always_comb begin
    out_nxt.used_regression = pf_r.rgr;
    out_nxt.saturated       = 1'b0;
    if (!pf_r.rgr) begin
      out_nxt.heat_index_f = pf_r.simple;
    end else if (hv > 64'sd32767) begin
      out_nxt.heat_index_f = 16'sh7FFF;
      out_nxt.saturated    = 1'b1;
    end else if (hv < -64'sd32768) begin
      out_nxt.heat_index_f = 16'sh8000;
      out_nxt.saturated    = 1'b1;
    end else begin
      out_nxt.heat_index_f = hv[15:0];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  // Valid bits travel alongside the data.
  logic [RT_W+2:0] vld_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[RT_W+1:0], start};
      out_valid_r <= vld_r[RT_W+2];
    end
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic simple_ok, on_rail;

  assign simple_ok = !out_data_r.saturated && (out_data_r.heat_index_f <= 16'sd1264);
  assign on_rail   = (out_data_r.heat_index_f == 16'sh7FFF) ||
                     (out_data_r.heat_index_f == 16'sh8000);

  `HIC_ASSERT_NOW(a_latency, out_valid_r, $past(start, LAT))
  `HIC_ASSERT_NOW(a_simple_range, out_valid_r && !out_data_r.used_regression, simple_ok)
  `HIC_ASSERT_NOW(a_sat_rail, out_valid_r && out_data_r.saturated, on_rail)
  `HIC_ASSERT_RESET(a_reset_quiet, !rst_n, !out_valid_r)

endmodule

`default_nettype wire
